>>> hdl/base32_stream_codec_macros.svh
// Assertion macros shared by the base32 stream codec modules.
`ifndef BASE32_STREAM_CODEC_MACROS_SVH
`define BASE32_STREAM_CODEC_MACROS_SVH

// Property checked every cycle outside reset.
`define B32C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked from the cycle after the trigger.
`define B32C_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

>>> hdl/b32c_pkg.sv
// Shared types, constants and functions of the base32 stream codec.
package b32c_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One accepted item as classified by the front: up to three results.
  typedef struct packed {
    logic            dec;
    logic [1:0]      n;
    logic [2:0][7:0] val;
    logic            present;
    logic            bad;
    logic            last;
  } job_t;

  // Decode one character: {valid, 5-bit value}.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      char_value = 6'b0;
      if (c inside {[8'h41:8'h5A]}) begin
        d = c - 8'h41;
        char_value = {1'b1, d[4:0]};
      end else if (c inside {[8'h61:8'h7A]}) begin
        d = c - 8'h61;
        char_value = {1'b1, d[4:0]};
      end else if (c inside {[8'h32:8'h37]}) begin
        d = c - 8'h18;
        char_value = {1'b1, d[4:0]};
      end
    end
  endfunction

  // 5-bit group to alphabet character.
  function automatic logic [7:0] b32_char(input logic [4:0] g);
    begin
      if (g < 5'd26) begin
        b32_char = 8'h41 + {3'b0, g};
      end else begin
        b32_char = 8'h18 + {3'b0, g};
      end
    end
  endfunction

endpackage

>>> hdl/base32_stream_codec.sv
// An accepted item's job is registered in the job queue, and the back reads its results from the queue head.
// The front takes one item per cycle unless the queue is full; the back gives one result a cycle
// while out_stall is low, so an encoded byte (one to three characters) leaves one character at a time.
// A four-entry job queue sets how far the front runs ahead of a stalled output.
// Reset (rst, synchronous) sets encode, clears the bit store and empties the queue.
module base32_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       write_enable,
  input  logic       write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic       out_present,
  output logic       out_bad,
  output logic       out_end
);
  import b32c_pkg::*;

  job_t q_din, q_dout;
  logic q_push, q_pop, q_full, q_empty;

  b32c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_end       (in_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_din        (q_din)
  );

  b32c_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  b32c_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_present (out_present),
    .out_bad     (out_bad),
    .out_end     (out_end)
  );

endmodule

>>> hdl/b32c_front.sv
// Front: accepts items, keeps the bit store and pushes one job per item that has results.
module b32c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_enable,
  input  logic              write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_value,
  input  logic              in_end,
  input  logic              q_full,
  output logic              q_push,
  output b32c_pkg::job_t    q_din
);
  import b32c_pkg::*;

  logic        direction;
  logic [11:0] bit_store, bit_store_next;
  logic [3:0]  bit_count, bit_count_next;
  logic        discarding, discarding_next;
  logic        accept;

  // encode
  logic [11:0] s_enc, keep_enc;
  logic [3:0]  cnt_enc, r_enc;
  logic        two_groups;
  logic [4:0]  g0, g1, g_tail;
  logic [11:0] sh0, sh1;
  logic [2:0]  tail_shamt;
  logic [16:0] tail_w;

  // decode
  logic [5:0]  cv;
  logic [11:0] s_dec, keep_dec, sh_dec;
  logic [3:0]  cnt_dec, rem_dec;
  logic        has_byte;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s_enc      = {bit_store[3:0], in_value};
    cnt_enc    = bit_count + 4'd8;
    two_groups = cnt_enc >= 4'd10;
    sh0        = s_enc >> (cnt_enc - 4'd5);
    sh1        = s_enc >> (cnt_enc - 4'd10);
    g0         = sh0[4:0];
    g1         = sh1[4:0];
    r_enc      = two_groups ? cnt_enc - 4'd10 : cnt_enc - 4'd5;
    tail_shamt = 3'd5 - r_enc[2:0];
    tail_w     = {5'b0, s_enc} << tail_shamt;
    g_tail     = tail_w[4:0];
    keep_enc   = s_enc & ((12'd1 << r_enc) - 12'd1);

    cv       = char_value(in_value);
    s_dec    = {bit_store[6:0], cv[4:0]};
    cnt_dec  = bit_count + 4'd5;
    has_byte = cnt_dec >= 4'd8;
    rem_dec  = cnt_dec - 4'd8;
    sh_dec   = s_dec >> rem_dec;
    keep_dec = s_dec & ((12'd1 << rem_dec) - 12'd1);

    q_din           = '0;
    q_din.dec       = direction;
    q_din.last      = in_end;
    bit_store_next  = bit_store;
    bit_count_next  = bit_count;
    discarding_next = discarding;

    if (!direction) begin
      q_din.present  = 1'b1;
      q_din.val[0]   = {3'b0, g0};
      q_din.val[1]   = two_groups ? {3'b0, g1} : {3'b0, g_tail};
      q_din.val[2]   = {3'b0, g_tail};
      q_din.n        = (two_groups ? 2'd2 : 2'd1) +
                       ((in_end && r_enc != 4'd0) ? 2'd1 : 2'd0);
      bit_store_next = in_end ? 12'd0 : keep_enc;
      bit_count_next = in_end ? 4'd0 : r_enc;
    end else if (discarding) begin
      q_din.n         = 2'd0;
      discarding_next = !in_end;
    end else if (!cv[5]) begin
      q_din.n         = 2'd1;
      q_din.bad       = 1'b1;
      q_din.last      = 1'b1;
      bit_store_next  = 12'd0;
      bit_count_next  = 4'd0;
      discarding_next = !in_end;
    end else begin
      if (has_byte) begin
        q_din.n        = 2'd1;
        q_din.present  = 1'b1;
        q_din.val[0]   = sh_dec[7:0];
        bit_store_next = keep_dec;
        bit_count_next = rem_dec;
      end else begin
        q_din.n        = in_end ? 2'd1 : 2'd0;
        bit_store_next = s_dec;
        bit_count_next = cnt_dec;
      end
      if (in_end) begin
        bit_store_next = 12'd0;
        bit_count_next = 4'd0;
      end
    end
  end

  assign q_push = accept && (q_din.n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      bit_store  <= 12'd0;
      bit_count  <= 4'd0;
      discarding <= 1'b0;
    end else if (write_enable) begin
      direction  <= write_data;
      bit_store  <= 12'd0;
      bit_count  <= 4'd0;
      discarding <= 1'b0;
    end else if (accept) begin
      bit_store  <= bit_store_next;
      bit_count  <= bit_count_next;
      discarding <= discarding_next;
    end
  end

`include "base32_stream_codec_macros.svh"
  `B32C_ASSERT_NEXT(a_cfg_clears, write_enable, bit_count == 4'd0 && !discarding, "config write did not clear state")
  `B32C_ASSERT(a_enc_count, direction || bit_count <= 4'd4, "encode bit count out of range")
  `B32C_ASSERT(a_dec_count, !direction || bit_count <= 4'd7, "decode bit count out of range")

endmodule

>>> hdl/b32c_queue.sv
// Job queue between front and back.
module b32c_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b32c_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output b32c_pkg::job_t dout,
  output logic           empty
);
  import b32c_pkg::*;

  job_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  assign full  = count == QCW'(QDEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

`include "base32_stream_codec_macros.svh"
  `B32C_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `B32C_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

>>> hdl/b32c_back.sv
// Back: walks the results of the head job and drives the output channel.
module b32c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  b32c_pkg::job_t q_dout,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_value,
  output logic           out_present,
  output logic           out_bad,
  output logic           out_end
);
  import b32c_pkg::*;

  logic [1:0] idx;
  logic       last_res;
  logic       take;

  assign out_valid = !q_empty;
  assign last_res  = idx == (q_dout.n - 2'd1);
  assign take      = out_valid && !out_stall;
  assign q_pop     = take && last_res;

  always_comb begin
    out_value   = q_dout.dec ? q_dout.val[idx] : b32_char(q_dout.val[idx][4:0]);
    out_present = q_dout.present;
    out_bad     = q_dout.bad;
    out_end     = q_dout.last && last_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last_res ? 2'd0 : idx + 2'd1;
    end
  end

`include "base32_stream_codec_macros.svh"
  `B32C_ASSERT(a_idx_in_job, !out_valid || (q_dout.n != 2'd0 && idx < q_dout.n), "result index outside job")

endmodule
